// ===== rtl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants for the sensor mismatch fault monitor
// Holds the item and result layouts, register indexes, reset values and
// sensor selection codes used across the monitor's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

    localparam int ADIFF_W        = 24;
    localparam int DELTA_W        = 24;
    localparam int TIME_W         = 32;
    localparam int THRESH_W       = 24;
    localparam int CFG_W          = 32;
    localparam int MAX_WINDOW_DEF = 256;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 24'd4575;
    localparam logic [TIME_W-1:0]   TTF_RESET    = 32'd1000;

    // register indexes on the configuration port
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_TIME_TO_FAULT = 1'b1;

    // item kinds
    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RECOVER = 1'b1;

    // fault kinds
    localparam logic KIND_NONE     = 1'b0;
    localparam logic KIND_MISMATCH = 1'b1;

    // fine sensor selection
    localparam logic [1:0] SEL_PRIMARY = 2'd1;
    localparam logic [1:0] SEL_BACKUP  = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [ADIFF_W-1:0] adiff;
        logic               last_sample;
        logic [TIME_W-1:0]  time_ms;
    } item_t;

    typedef struct packed {
        logic       faulted;
        logic       recovering;
        logic       fault_kind;
        logic [1:0] sensor_select;
        logic       fault_alert;
        logic       window_exceeded;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/sme_front.sv =====
// ----------------------------------------------------------------------------
// sme_front: input register
// Forms the absolute angle difference of an incoming item and holds the
// item until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          mode,
    input  wire logic signed [sme_pkg::DELTA_W-1:0] coarse_delta,
    input  wire logic signed [sme_pkg::DELTA_W-1:0] fine_delta,
    input  wire logic                          last_sample,
    input  wire logic [sme_pkg::TIME_W-1:0]    time_ms,
    input  wire logic                          advance,
    output logic                               item_valid,
    output sme_pkg::item_t                     item
);
    import sme_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    item_t                item_reg;
    logic signed [DELTA_W:0] diff;
    logic [DELTA_W:0]     mag;
    logic                 take;

    // fine - coarse spans 25 bits; its magnitude always fits in 24
    assign diff = {fine_delta[DELTA_W-1], fine_delta} - {coarse_delta[DELTA_W-1], coarse_delta};
    assign mag  = diff[DELTA_W] ? (~diff + 1'b1) : diff;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.mode        <= mode;
            item_reg.adiff       <= mag[ADIFF_W-1:0];
            item_reg.last_sample <= last_sample;
            item_reg.time_ms     <= time_ms;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/sme_core.sv =====
// ----------------------------------------------------------------------------
// sme_core: window accumulator, persistence timer and fault state
// Holds the configuration registers and all monitor state, and works out
// the result of an item in the cycle it leaves the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_core #(
    parameter int MAX_WINDOW = sme_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [sme_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       fire,
    input  wire sme_pkg::item_t             item,
    output logic                            has_result,
    output sme_pkg::result_t                result
);
    import sme_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = ADIFF_W + $clog2(MAX_WINDOW);
    localparam int PROD_W = THRESH_W + CNT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW);

    logic [THRESH_W-1:0] thresh_reg;
    logic [TIME_W-1:0]   ttf_reg;

    logic [SUM_W-1:0]  sum_reg,  sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              latched_reg, latched_next;
    logic              recov_reg, recov_next;
    logic              kind_reg, kind_next;
    logic              persist_reg, persist_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic              pending_reg, pending_next;
    logic [1:0]        sel_reg, sel_next;

    logic              is_sample;
    logic              window_end;
    logic              add_ok;
    logic [SUM_W-1:0]  sum_acc;
    logic [CNT_W-1:0]  count_acc;
    logic [PROD_W-1:0] limit;
    logic              exceeded;
    logic [TIME_W-1:0] elapsed;
    logic              overdue;
    logic              detected;
    logic              alert;

    assign is_sample  = (item.mode == MODE_SAMPLE);
    assign window_end = is_sample && item.last_sample;

    // samples past the window limit are dropped, the window still ends
    assign add_ok    = !latched_reg && (count_reg < CNT_MAX);
    assign sum_acc   = add_ok ? (sum_reg + SUM_W'(item.adiff)) : sum_reg;
    assign count_acc = add_ok ? (count_reg + 1'b1) : count_reg;
    assign limit     = PROD_W'(thresh_reg) * PROD_W'(count_acc);
    assign exceeded  = !latched_reg && (PROD_W'(sum_acc) > limit);

    assign elapsed  = item.time_ms - start_reg;
    assign overdue  = elapsed > ttf_reg;
    assign detected = exceeded && (persist_reg || recov_reg) && overdue;
    assign alert    = detected && !recov_reg && !latched_reg;

    always_comb
    begin
        sum_next     = sum_reg;
        count_next   = count_reg;
        latched_next = latched_reg;
        recov_next   = recov_reg;
        kind_next    = kind_reg;
        persist_next = persist_reg;
        start_next   = start_reg;
        pending_next = pending_reg;
        sel_next     = sel_reg;

        if (fire)
        begin
            if (!is_sample)
            begin
                pending_next = 1'b1;
            end
            else if (latched_reg)
            begin
                if (item.last_sample)
                begin
                    sum_next   = '0;
                    count_next = '0;
                    if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        if (kind_reg == KIND_MISMATCH)
                        begin
                            sel_next = SEL_BACKUP;
                        end
                        latched_next = 1'b0;
                        recov_next   = 1'b1;
                    end
                end
            end
            else if (!item.last_sample)
            begin
                sum_next   = sum_acc;
                count_next = count_acc;
            end
            else
            begin
                sum_next   = '0;
                count_next = '0;
                // persistence timer
                if (!exceeded)
                begin
                    persist_next = 1'b0;
                end
                else if (!persist_reg && !recov_reg)
                begin
                    start_next   = item.time_ms;
                    persist_next = 1'b1;
                end
                else if (overdue && persist_reg)
                begin
                    persist_next = 1'b0;
                end
                // fault decision
                if (detected)
                begin
                    if (!recov_reg)
                    begin
                        kind_next    = KIND_MISMATCH;
                        latched_next = 1'b1;
                    end
                end
                else
                begin
                    kind_next  = KIND_NONE;
                    recov_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= THRESH_RESET;
            ttf_reg     <= TTF_RESET;
            sum_reg     <= '0;
            count_reg   <= '0;
            latched_reg <= 1'b0;
            recov_reg   <= 1'b0;
            kind_reg    <= KIND_NONE;
            persist_reg <= 1'b0;
            start_reg   <= '0;
            pending_reg <= 1'b0;
            sel_reg     <= SEL_PRIMARY;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_THRESHOLD:     thresh_reg <= cfg_data[THRESH_W-1:0];
                    REG_TIME_TO_FAULT: ttf_reg    <= cfg_data[TIME_W-1:0];
                    default:           thresh_reg <= thresh_reg;
                endcase
            end
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            latched_reg <= latched_next;
            recov_reg   <= recov_next;
            kind_reg    <= kind_next;
            persist_reg <= persist_next;
            start_reg   <= start_next;
            pending_reg <= pending_next;
            sel_reg     <= sel_next;
        end
    end

    assign has_result = window_end;

    assign result.faulted         = latched_next;
    assign result.recovering      = recov_next;
    assign result.fault_kind      = kind_next;
    assign result.sensor_select   = sel_next;
    assign result.fault_alert     = alert;
    assign result.window_exceeded = exceeded;

    a_alert_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && has_result && result.fault_alert) |=> latched_reg)
        else $error("alert without latched fault");

    a_latch_excl_recov: assert property (@(posedge clk) disable iff (!rst_n)
        !(latched_reg && recov_reg))
        else $error("fault latched while recovering");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("window count past limit");

    a_sel_code: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg == SEL_PRIMARY) || (sel_reg == SEL_BACKUP))
        else $error("bad sensor selection");

    a_window_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && has_result) |=> (count_reg == '0))
        else $error("window not cleared at its end");

endmodule

`default_nettype wire

// ===== rtl/sme_out.sv =====
// ----------------------------------------------------------------------------
// sme_out: result register
// Holds a finished result until the consumer takes it, and tells the
// front end when the core may hand over a new item.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              has_result,
    input  wire sme_pkg::result_t  result,
    output logic                   advance,
    output logic                   fire,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sme_pkg::result_t       out_result
);
    import sme_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    logic    load;
    result_t result_reg;

    // free when empty or being taken this cycle
    assign advance = !valid_reg || !out_stall;
    assign fire    = item_valid && advance;
    assign load    = fire && has_result;

    assign valid_next = advance ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/sensor_mismatch_fault_monitor.sv =====
// Throughput: one item per cycle while out_stall does not hold the result register.
// A window's result is loaded when its last sample leaves the input register; the
// window sum, threshold product and timer test settle combinationally in between.
// Recovery commands and samples that do not end a window give no result.
// Reset (rst_n, asynchronous, active low) clears the window and fault state, selects
// the primary sensor and loads the default threshold and time to fault.
// ----------------------------------------------------------------------------
// sensor_mismatch_fault_monitor: top level
// Compares coarse and fine sensor angle deltas over windows and latches a
// mismatch fault when the window mean stays above threshold too long.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_mismatch_fault_monitor #(
    parameter int MAX_WINDOW = sme_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [sme_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               mode,
    input  wire logic signed [sme_pkg::DELTA_W-1:0] coarse_delta,
    input  wire logic signed [sme_pkg::DELTA_W-1:0] fine_delta,
    input  wire logic                               last_sample,
    input  wire logic [sme_pkg::TIME_W-1:0]         time_ms,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    faulted,
    output logic                                    recovering,
    output logic                                    fault_kind,
    output logic [1:0]                              sensor_select,
    output logic                                    fault_alert,
    output logic                                    window_exceeded
);
    import sme_pkg::*;

    logic    advance;
    logic    fire;
    logic    item_valid;
    item_t   item;
    logic    has_result;
    result_t result;
    result_t out_result;

    sme_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .coarse_delta (coarse_delta),
        .fine_delta   (fine_delta),
        .last_sample  (last_sample),
        .time_ms      (time_ms),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item)
    );

    sme_core #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fire       (fire),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    sme_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .has_result (has_result),
        .result     (result),
        .advance    (advance),
        .fire       (fire),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign faulted         = out_result.faulted;
    assign recovering      = out_result.recovering;
    assign fault_kind      = out_result.fault_kind;
    assign sensor_select   = out_result.sensor_select;
    assign fault_alert     = out_result.fault_alert;
    assign window_exceeded = out_result.window_exceeded;

endmodule

`default_nettype wire
